// ----- src/h264_rtp_fua_packetizer_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef H264_RTP_FUA_PACKETIZER_CORE_DEFINES_SVH
`define H264_RTP_FUA_PACKETIZER_CORE_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define H264FUA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also looks at cycles in reset.
`define H264FUA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/h264fua_pkg.sv -----
`default_nettype none
package h264fua_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TS_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd3;

  localparam logic [6:0]  RST_PAYLOAD_TYPE  = 7'd96;
  localparam logic [31:0] RST_SOURCE_ID     = 32'd10;
  localparam logic [31:0] RST_TS_STEP       = 32'd3600;
  localparam logic [10:0] RST_PAYLOAD_LIMIT = 11'd1400;
  localparam logic [10:0] LIMIT_MIN         = 11'd64;
  localparam logic [10:0] LIMIT_MAX         = 11'd1460;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [4:0] FU_A_TYPE        = 5'd28;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] STEP_VERSION  = 4'd0;
  localparam logic [3:0] STEP_PT       = 4'd1;
  localparam logic [3:0] STEP_SEQ_HI   = 4'd2;
  localparam logic [3:0] STEP_SEQ_LO   = 4'd3;
  localparam logic [3:0] STEP_TS_3     = 4'd4;
  localparam logic [3:0] STEP_TS_2     = 4'd5;
  localparam logic [3:0] STEP_TS_1     = 4'd6;
  localparam logic [3:0] STEP_TS_0     = 4'd7;
  localparam logic [3:0] STEP_SSRC_3   = 4'd8;
  localparam logic [3:0] STEP_SSRC_2   = 4'd9;
  localparam logic [3:0] STEP_SSRC_1   = 4'd10;
  localparam logic [3:0] STEP_SSRC_0   = 4'd11;
  localparam logic [3:0] STEP_FU_IND   = 4'd12;
  localparam logic [3:0] STEP_FU_HDR   = 4'd13;
  localparam logic [3:0] STEP_DATA     = 4'd14;

  typedef struct packed {
    logic        hdr;
    logic        fu;
    logic        has_byte;
    logic        marker;
    logic        fu_start;
    logic        fu_end;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [7:0]  nal;
    logic [7:0]  data;
    logic        data_end;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/h264fua_queue.sv -----
`default_nettype none
module h264fua_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  h264fua_pkg::cmd_t   push_cmd,
  output logic                full,
  input  wire                 pop,
  output logic                empty,
  output h264fua_pkg::cmd_t   head
);

  localparam int unsigned AW = h264fua_pkg::QUEUE_AW;
  localparam int unsigned DEPTH = h264fua_pkg::QUEUE_DEPTH;

  h264fua_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- src/h264fua_front.sv -----
`default_nettype none
module h264fua_front #(
  parameter int unsigned MAX_UNIT_BYTES = 1048576
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [h264fua_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [31:0]                           cfg_data,
  input  wire                                   in_push,
  input  wire  [7:0]                            in_data_byte,
  input  wire                                   in_first_of_unit,
  input  wire  [20:0]                           in_unit_length,
  input  wire                                   q_full,
  output logic                                  q_push,
  output h264fua_pkg::cmd_t                     q_cmd
);

  localparam int unsigned LW = $clog2(MAX_UNIT_BYTES + 1);
  localparam int unsigned CW = (LW > 21) ? LW : 21;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_UNIT_BYTES);

  logic [6:0]    pt_r;
  logic [31:0]   ssrc_r;
  logic [31:0]   tstep_r;
  logic [10:0]   limit_r;

  logic [15:0]   seq_r, seq_nxt;
  logic [31:0]   ts_r, ts_nxt;
  logic [LW-1:0] ubl_r, ubl_nxt;
  logic [10:0]   pbl_r, pbl_nxt;
  logic [7:0]    nal_r, nal_nxt;
  logic          frag_r, frag_nxt;

  logic [10:0]   lim;
  logic [LW-1:0] lim_ext;
  logic [CW-1:0] len_ext, len_c;
  logic [LW-1:0] len_w, chunk_first, chunk_n, ubl_d;
  logic [10:0]   pbl_a, pbl_d;
  logic          accept, is_short, need_hdr, last_n;
  logic [31:0]   ts_add;

  always_comb begin
    if (limit_r < h264fua_pkg::LIMIT_MIN) begin
      lim = h264fua_pkg::LIMIT_MIN;
    end else if (limit_r > h264fua_pkg::LIMIT_MAX) begin
      lim = h264fua_pkg::LIMIT_MAX;
    end else begin
      lim = limit_r;
    end
  end

  assign lim_ext = LW'(lim);
  assign len_ext = CW'(in_unit_length);
  assign ts_add  = ts_r + tstep_r;
  assign accept  = in_push && !q_full;

  always_comb begin
    if (len_ext == '0) begin
      len_c = CW'(1);
    end else if (len_ext > MAX_LEN) begin
      len_c = MAX_LEN;
    end else begin
      len_c = len_ext;
    end
  end

  assign len_w       = LW'(len_c);
  assign is_short    = (len_w <= lim_ext);
  assign chunk_first = ((len_w - LW'(2)) > lim_ext) ? lim_ext : (len_w - LW'(2));
  assign chunk_n     = (ubl_r > lim_ext) ? lim_ext : ubl_r;
  assign last_n      = (ubl_r <= lim_ext);
  assign need_hdr    = frag_r && (pbl_r == '0);
  assign pbl_a       = need_hdr ? chunk_n[10:0] : pbl_r;
  assign pbl_d       = (pbl_a != '0) ? (pbl_a - 1'b1) : '0;
  assign ubl_d       = ubl_r - 1'b1;

  always_comb begin
    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    ubl_nxt  = ubl_r;
    pbl_nxt  = pbl_r;
    nal_nxt  = nal_r;
    frag_nxt = frag_r;
    q_push   = 1'b0;

    q_cmd          = '0;
    q_cmd.pt       = pt_r;
    q_cmd.ssrc     = ssrc_r;
    q_cmd.seq      = seq_r;
    q_cmd.ts       = ts_r;
    q_cmd.nal      = nal_r;
    q_cmd.data     = in_data_byte;

    if (accept) begin
      if (in_first_of_unit) begin
        q_push      = 1'b1;
        ts_nxt      = ts_add;
        nal_nxt     = in_data_byte;
        ubl_nxt     = len_w - 1'b1;
        seq_nxt     = seq_r + 1'b1;
        q_cmd.ts    = ts_add;
        q_cmd.nal   = in_data_byte;
        q_cmd.hdr   = 1'b1;
        if (is_short) begin
          frag_nxt       = 1'b0;
          pbl_nxt        = 11'(len_w - 1'b1);
          q_cmd.marker   = 1'b1;
          q_cmd.has_byte = 1'b1;
          q_cmd.data_end = (len_w == LW'(1));
        end else begin
          frag_nxt       = 1'b1;
          pbl_nxt        = chunk_first[10:0];
          q_cmd.fu       = 1'b1;
          q_cmd.fu_start = 1'b1;
        end
      end else if (ubl_r != '0) begin
        q_push         = 1'b1;
        q_cmd.has_byte = 1'b1;
        if (need_hdr) begin
          seq_nxt      = seq_r + 1'b1;
          q_cmd.hdr    = 1'b1;
          q_cmd.fu     = 1'b1;
          q_cmd.marker = last_n;
          q_cmd.fu_end = last_n;
        end
        pbl_nxt        = pbl_d;
        ubl_nxt        = ubl_d;
        q_cmd.data_end = (pbl_d == '0);
        if (ubl_d == '0) begin
          frag_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r    <= h264fua_pkg::RST_PAYLOAD_TYPE;
      ssrc_r  <= h264fua_pkg::RST_SOURCE_ID;
      tstep_r <= h264fua_pkg::RST_TS_STEP;
      limit_r <= h264fua_pkg::RST_PAYLOAD_LIMIT;
      seq_r   <= '0;
      ts_r    <= '0;
      ubl_r   <= '0;
      pbl_r   <= '0;
      nal_r   <= '0;
      frag_r  <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      ubl_r  <= ubl_nxt;
      pbl_r  <= pbl_nxt;
      nal_r  <= nal_nxt;
      frag_r <= frag_nxt;
      if (cfg_we) begin
        case (cfg_index)
          h264fua_pkg::CFG_PAYLOAD_TYPE:  pt_r    <= cfg_data[6:0];
          h264fua_pkg::CFG_SOURCE_ID:     ssrc_r  <= cfg_data;
          h264fua_pkg::CFG_TS_STEP:       tstep_r <= cfg_data;
          h264fua_pkg::CFG_PAYLOAD_LIMIT: limit_r <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/h264fua_back.sv -----
`default_nettype none
module h264fua_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_empty,
  input  h264fua_pkg::cmd_t   q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  wire                 out_pop,
  output logic [7:0]          out_byte,
  output logic                out_packet_end,
  output logic                out_run_last
);

  logic       mid_r, mid_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       end_r, last_r;

  logic [3:0] cur;
  logic [3:0] next_step;
  logic       done;
  logic       advance;
  logic [7:0] byte_val;

  always_comb begin
    if (mid_r) begin
      cur = step_r;
    end else if (q_head.hdr) begin
      cur = h264fua_pkg::STEP_VERSION;
    end else begin
      cur = h264fua_pkg::STEP_DATA;
    end
  end

  always_comb begin
    done      = 1'b0;
    next_step = cur + 1'b1;
    case (cur)
      h264fua_pkg::STEP_SSRC_0: begin
        next_step = q_head.fu ? h264fua_pkg::STEP_FU_IND : h264fua_pkg::STEP_DATA;
      end
      h264fua_pkg::STEP_FU_HDR: begin
        next_step = h264fua_pkg::STEP_DATA;
        done      = !q_head.has_byte;
      end
      h264fua_pkg::STEP_DATA: begin
        done = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cur)
      h264fua_pkg::STEP_VERSION: byte_val = h264fua_pkg::RTP_VERSION_BYTE;
      h264fua_pkg::STEP_PT:      byte_val = {q_head.marker, q_head.pt};
      h264fua_pkg::STEP_SEQ_HI:  byte_val = q_head.seq[15:8];
      h264fua_pkg::STEP_SEQ_LO:  byte_val = q_head.seq[7:0];
      h264fua_pkg::STEP_TS_3:    byte_val = q_head.ts[31:24];
      h264fua_pkg::STEP_TS_2:    byte_val = q_head.ts[23:16];
      h264fua_pkg::STEP_TS_1:    byte_val = q_head.ts[15:8];
      h264fua_pkg::STEP_TS_0:    byte_val = q_head.ts[7:0];
      h264fua_pkg::STEP_SSRC_3:  byte_val = q_head.ssrc[31:24];
      h264fua_pkg::STEP_SSRC_2:  byte_val = q_head.ssrc[23:16];
      h264fua_pkg::STEP_SSRC_1:  byte_val = q_head.ssrc[15:8];
      h264fua_pkg::STEP_SSRC_0:  byte_val = q_head.ssrc[7:0];
      h264fua_pkg::STEP_FU_IND:  byte_val = {q_head.nal[7:5], h264fua_pkg::FU_A_TYPE};
      h264fua_pkg::STEP_FU_HDR:  byte_val = {q_head.fu_start, q_head.fu_end, 1'b0,
                                            q_head.nal[4:0]};
      h264fua_pkg::STEP_DATA:    byte_val = q_head.data;
      default:                   byte_val = '0;
    endcase
  end

  assign advance = !q_empty && (!out_valid_r || out_pop);
  assign q_pop   = advance && done;

  always_comb begin
    mid_nxt       = mid_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      mid_nxt       = !done;
      step_nxt      = next_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r       <= 1'b0;
      step_r      <= h264fua_pkg::STEP_VERSION;
      out_valid_r <= 1'b0;
    end else begin
      mid_r       <= mid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= byte_val;
      end_r  <= (cur == h264fua_pkg::STEP_DATA) && q_head.data_end;
      last_r <= done;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_byte       = byte_r;
  assign out_packet_end = end_r;
  assign out_run_last   = last_r;

endmodule
`default_nettype wire

// ----- src/h264_rtp_fua_packetizer_core.sv -----
// Channel   Direction  Handshake          Payload
// cfg       in         cfg_we             cfg_index, cfg_data
// in        in         in_push, in_full   in_data_byte, in_first_of_unit, in_unit_length
// out       out        out_pop, out_empty out_byte, out_packet_end, out_run_last
//
// A payload byte is one output word; a packet header adds 12, or 14 for a fragment.
// The output sequencer emits one word per cycle unless the queue is empty or the output
// is stalled, and sets the throughput. A four-entry command queue separates the input
// classifier from the sequencer. An input word reaches the output through the queue and
// the output register. Reset is synchronous; after it the block takes input at once.
`default_nettype none
module h264_rtp_fua_packetizer_core #(
  parameter int unsigned MAX_UNIT_BYTES = 1048576
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [h264fua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [31:0]                        cfg_data,
  input  wire                                in_push,
  output logic                               in_full,
  input  wire  [7:0]                         in_data_byte,
  input  wire                                in_first_of_unit,
  input  wire  [20:0]                        in_unit_length,
  output logic                               out_empty,
  input  wire                                out_pop,
  output logic [7:0]                         out_byte,
  output logic                               out_packet_end,
  output logic                               out_run_last
);

  h264fua_pkg::cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_empty;

  assign in_full = q_full;

  h264fua_front #(
    .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_first_of_unit (in_first_of_unit),
    .in_unit_length   (in_unit_length),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  h264fua_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  h264fua_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (head_cmd),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_run_last   (out_run_last)
  );

endmodule
`default_nettype wire

// ----- src/h264fua_checker.sv -----
`default_nettype none
`include "h264_rtp_fua_packetizer_core_defines.svh"
module h264fua_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_full,
  input wire       out_empty,
  input wire       out_pop,
  input wire [7:0] out_byte,
  input wire       out_packet_end,
  input wire       out_run_last
);

  // Nothing is waiting right after a reset cycle.
  `H264FUA_ASSERT_RST(a_reset_empty, !rst_n |=> out_empty, "output not empty after reset")
  // A word that closes a packet is always a payload word, so it ends its input word too.
  `H264FUA_ASSERT(a_end_is_last, (!out_empty && out_packet_end) |-> out_run_last, "packet end without run last")
  // The queue can only fill up while a result is waiting.
  `H264FUA_ASSERT(a_full_has_out, in_full |-> !out_empty, "input full with no result waiting")
  `H264FUA_ASSERT(a_out_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) && $stable(out_packet_end)), "stalled result changed")

endmodule

bind h264_rtp_fua_packetizer_core h264fua_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_byte       (out_byte),
  .out_packet_end (out_packet_end),
  .out_run_last   (out_run_last)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;

  localparam int unsigned UNIT_CAP = 1048576;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic [20:0] len;
  } nal_word_t;

  typedef struct {
    logic [7:0] b;
    logic       pend;
    logic       last;
  } rtp_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [h264fua_pkg::CFG_IDX_W-1:0] cfg_index = h264fua_pkg::CFG_PAYLOAD_TYPE;
  logic [31:0]                       cfg_data = '0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  logic [7:0]                        in_data_byte = '0;
  logic                              in_first_of_unit = 1'b0;
  logic [20:0]                       in_unit_length = '0;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic [7:0]                        out_byte;
  logic                              out_packet_end;
  logic                              out_run_last;

  h264_rtp_fua_packetizer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_first_of_unit (in_first_of_unit),
    .in_unit_length   (in_unit_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_packet_end   (out_packet_end),
    .out_run_last     (out_run_last)
  );

  always #5 clk = ~clk;

  // Register shadows and packetizer state used to predict the output stream.
  logic [6:0]  pt_reg = h264fua_pkg::RST_PAYLOAD_TYPE;
  logic [31:0] ssrc_reg = h264fua_pkg::RST_SOURCE_ID;
  logic [31:0] ts_step_reg = h264fua_pkg::RST_TS_STEP;
  logic [10:0] limit_reg = h264fua_pkg::RST_PAYLOAD_LIMIT;
  logic [15:0] seq_no = '0;
  logic [31:0] ts_now = '0;
  logic [20:0] unit_left = '0;
  logic [10:0] pkt_left = '0;
  logic [7:0]  nal_hdr = '0;
  logic        frag_on = 1'b0;

  nal_word_t nal_words[$];
  rtp_word_t rtp_expected[$];

  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 10;
  bit          hold_req = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  function automatic int unsigned lim_now();
    int unsigned l;
    l = limit_reg;
    if (l < h264fua_pkg::LIMIT_MIN) l = h264fua_pkg::LIMIT_MIN;
    if (l > h264fua_pkg::LIMIT_MAX) l = h264fua_pkg::LIMIT_MAX;
    return l;
  endfunction

  function automatic void put_word(logic [7:0] b, logic pend);
    rtp_word_t w;
    w.b = b;
    w.pend = pend;
    w.last = 1'b0;
    rtp_expected.push_back(w);
  endfunction

  function automatic void put_rtp_header(logic marker);
    put_word(h264fua_pkg::RTP_VERSION_BYTE, 1'b0);
    put_word({marker, pt_reg}, 1'b0);
    put_word(seq_no[15:8], 1'b0);
    put_word(seq_no[7:0], 1'b0);
    put_word(ts_now[31:24], 1'b0);
    put_word(ts_now[23:16], 1'b0);
    put_word(ts_now[15:8], 1'b0);
    put_word(ts_now[7:0], 1'b0);
    put_word(ssrc_reg[31:24], 1'b0);
    put_word(ssrc_reg[23:16], 1'b0);
    put_word(ssrc_reg[15:8], 1'b0);
    put_word(ssrc_reg[7:0], 1'b0);
    seq_no = seq_no + 16'd1;
  endfunction

  function automatic void put_fu(logic s, logic e);
    put_word({nal_hdr[7:5], h264fua_pkg::FU_A_TYPE}, 1'b0);
    put_word({s, e, 1'b0, nal_hdr[4:0]}, 1'b0);
  endfunction

  function automatic void packetize(logic [7:0] b, logic first, logic [20:0] len_in);
    int unsigned len;
    int unsigned lim;
    int unsigned chunk;
    int unsigned mark;
    logic        last_frag;
    mark = rtp_expected.size();
    lim = lim_now();
    if (first) begin
      len = len_in;
      if (len == 0) len = 1;
      if (len > UNIT_CAP) len = UNIT_CAP;
      ts_now = ts_now + ts_step_reg;
      nal_hdr = b;
      unit_left = 21'(len - 1);
      if (len <= lim) begin
        frag_on = 1'b0;
        pkt_left = 11'(len - 1);
        put_rtp_header(1'b1);
        put_word(b, len == 1);
      end else begin
        chunk = len - 2;
        if (chunk > lim) chunk = lim;
        frag_on = 1'b1;
        pkt_left = 11'(chunk);
        put_rtp_header(1'b0);
        put_fu(1'b1, 1'b0);
      end
    end else if (unit_left != 0) begin
      if (frag_on && pkt_left == 0) begin
        chunk = unit_left;
        if (chunk > lim) chunk = lim;
        last_frag = (chunk == unit_left);
        pkt_left = 11'(chunk);
        put_rtp_header(last_frag);
        put_fu(1'b0, last_frag);
      end
      if (pkt_left > 0) pkt_left = pkt_left - 11'd1;
      unit_left = unit_left - 21'd1;
      put_word(b, pkt_left == 0);
      if (unit_left == 0) frag_on = 1'b0;
    end
    if (rtp_expected.size() > mark) rtp_expected[rtp_expected.size()-1].last = 1'b1;
  endfunction

  // Input driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (nal_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
      in_push <= 1'b1;
      in_data_byte <= nal_words[0].data;
      in_first_of_unit <= nal_words[0].first;
      in_unit_length <= nal_words[0].len;
    end else begin
      in_push <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      packetize(in_data_byte, in_first_of_unit, in_unit_length);
      void'(nal_words.pop_front());
    end
  end

  // Output side: random pops plus one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    rtp_word_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (rtp_expected.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: byte %02h end %0b last %0b",
                   out_byte, out_packet_end, out_run_last);
        mismatches++;
      end else begin
        w = rtp_expected.pop_front();
        if (out_byte !== w.b || out_packet_end !== w.pend || out_run_last !== w.last) begin
          if (mismatches < 10)
            $display("word mismatch: expected %02h/%0b/%0b actual %02h/%0b/%0b",
                     w.b, w.pend, w.last, out_byte, out_packet_end, out_run_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void put_nal(logic [7:0] data, logic first, logic [20:0] len);
    nal_word_t n;
    n.data = data;
    n.first = first;
    n.len = len;
    nal_words.push_back(n);
  endfunction

  function automatic void queue_unit(int unsigned len_field, int unsigned n_sent);
    put_nal(8'($urandom), 1'b1, 21'(len_field));
    for (int unsigned i = 1; i < n_sent; i++) put_nal(8'($urandom), 1'b0, 21'($urandom));
  endfunction

  function automatic void random_units(int unsigned target);
    int unsigned got;
    int unsigned lim;
    int unsigned len;
    int unsigned r;
    int unsigned sent;
    got = 0;
    while (got < target) begin
      lim = lim_now();
      r = $urandom_range(99);
      if (r < 10) begin
        put_nal(8'($urandom), 1'b0, 21'($urandom));
        got += 1;
      end else if (r < 30) begin
        len = $urandom_range(2, lim + 20);
        sent = $urandom_range(1, 6);
        if (sent > len - 1) sent = len - 1;
        queue_unit(len, sent);
        got += sent;
      end else begin
        len = $urandom_range(1, 12);
        queue_unit(len, len);
        got += len;
      end
    end
    queue_unit(3, 3);
  endfunction

  task automatic write_reg(logic [h264fua_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      h264fua_pkg::CFG_PAYLOAD_TYPE:  pt_reg = val[6:0];
      h264fua_pkg::CFG_SOURCE_ID:     ssrc_reg = val;
      h264fua_pkg::CFG_TS_STEP:       ts_step_reg = val;
      h264fua_pkg::CFG_PAYLOAD_LIMIT: limit_reg = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word is sent and every predicted word has come back.
  task automatic drain();
    while (nal_words.size() != 0 || rtp_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    queue_unit(5, 5);
    put_nal(8'($urandom), 1'b0, 21'($urandom));
    queue_unit(1, 1);
    queue_unit(0, 1);
    put_nal(8'hFF, 1'b1, 21'd3);
    put_nal(8'h00, 1'b0, 21'd0);
    put_nal(8'hFF, 1'b0, 21'h1FFFFF);
    put_nal(8'h00, 1'b0, 21'd0);
    drain();

    write_reg(h264fua_pkg::CFG_PAYLOAD_LIMIT, 32'd64);
    write_reg(h264fua_pkg::CFG_PAYLOAD_TYPE, 32'd127);
    write_reg(h264fua_pkg::CFG_SOURCE_ID, 32'hFFFF_FFFF);
    write_reg(h264fua_pkg::CFG_TS_STEP, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    queue_unit(65, 65);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_unit(200, 66);
    queue_unit(21'h1FFFFF, 3);
    queue_unit(3, 3);
    drain();
    tx_idle_pct = 10;
    rx_idle_pct = 10;

    write_reg(h264fua_pkg::CFG_PAYLOAD_LIMIT, 32'd2047);
    write_reg(h264fua_pkg::CFG_PAYLOAD_TYPE, 32'd0);
    write_reg(h264fua_pkg::CFG_SOURCE_ID, 32'd0);
    write_reg(h264fua_pkg::CFG_TS_STEP, 32'd0);
    queue_unit(1461, 3);
    queue_unit(1460, 2);
    drain();

    write_reg(h264fua_pkg::CFG_PAYLOAD_LIMIT, 32'd0);
    write_reg(h264fua_pkg::CFG_PAYLOAD_TYPE, $urandom);
    write_reg(h264fua_pkg::CFG_SOURCE_ID, $urandom);
    write_reg(h264fua_pkg::CFG_TS_STEP, $urandom);
    random_units(10);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
